### rtl/slist_pkg.sv
package slist_pkg;

   // Default number of entries the list can hold.
   localparam int CAPACITY_DEFAULT = 64;

   // Field widths.
   localparam int VALUE_W = 32;
   localparam int RANK_W  = 6;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;
   localparam int POS_W   = 6;
   localparam int OCC_W   = 7;

   // Operation codes; any other code reads.
   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd1;
   localparam logic [OP_W-1:0] OP_READ   = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_DONE    = 2'd0;
   localparam logic [STAT_W-1:0] STAT_FULL    = 2'd1;
   localparam logic [STAT_W-1:0] STAT_NO_RANK = 2'd2;

   // Command broadcast from the controller to every cell.
   typedef struct packed {
      logic                      active;     // execute cycle of an operation
      logic                      op_insert;  // operation is an insert (even if full)
      logic                      insert_go;  // insert that will be stored
      logic                      remove_go;  // remove of an occupied rank
      logic signed [VALUE_W-1:0] value;
      logic [RANK_W-1:0]         rank;
   } cell_cmd_type;

endpackage

### rtl/sorted_list_insert_remove.sv
// Sorted list of signed 32-bit values held in a row of compare-and-shift cells.
// Input channel: an operation (insert, remove at rank, read at rank) transfers
// at a rising edge where start is high and busy is low. Busy stays high while
// the operation occupies the cells, through the execute and gather states.
// Result channel: one result per operation, shown for exactly one cycle with
// rsp_strobe high; it cannot be held off and is lost if not taken.
// Sequence: the start transfer enters the execute state, then the gather
// state, whose outcome is registered as the result. A new operation may be
// started in the cycle the result is shown, not before. The execute state
// compares every cell against the operand and shifts the row in parallel; the
// gather state gathers the matching cell's rank and value across the whole row.
// An insert goes after all equal values. A full list drops the insert with the
// full status; a remove or read of an unoccupied rank reports rank not occupied.
// Reset (synchronous) empties the list and clears the controller; cell contents
// are left as they are and are never reported before being written.
module sorted_list_insert_remove #(
   parameter int CAPACITY = slist_pkg::CAPACITY_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [slist_pkg::OP_W-1:0]           req_operation,
   input  logic signed [slist_pkg::VALUE_W-1:0] req_value,
   input  logic [slist_pkg::RANK_W-1:0]         req_rank,
   output logic                                 rsp_strobe,
   output logic [slist_pkg::STAT_W-1:0]         rsp_status,
   output logic [slist_pkg::POS_W-1:0]          rsp_position,
   output logic signed [slist_pkg::VALUE_W-1:0] rsp_entry_value,
   output logic [slist_pkg::OCC_W-1:0]          rsp_occupancy
);
   import slist_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = CNT_W + RANK_W;
   localparam logic [CNT_W-1:0] CAP_C = CNT_W'(CAPACITY);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_EXEC   = 2'd1;
   localparam logic [1:0] S_REDUCE = 2'd2;

   logic [1:0]                state_ff, state_in;
   logic [OP_W-1:0]           op_ff;
   logic signed [VALUE_W-1:0] value_ff;
   logic [RANK_W-1:0]         rank_ff;
   logic [CNT_W-1:0]          count_ff, count_in;
   logic [STAT_W-1:0]         status_ff, status_in;

   logic                      rsp_strobe_ff;
   logic [STAT_W-1:0]         rsp_status_ff;
   logic [POS_W-1:0]          rsp_position_ff, position_in;
   logic signed [VALUE_W-1:0] rsp_value_ff, value_out_in;
   logic [OCC_W-1:0]          rsp_occupancy_ff;

   logic                      accept, is_insert, is_remove, full, rank_ok;
   logic [CNT_W+OCC_W-1:0]    count_ext;
   cell_cmd_type              cmd;

   logic                      le_chain  [CAPACITY];
   logic signed [VALUE_W-1:0] cell_val  [CAPACITY];
   logic                      cell_hit  [CAPACITY];
   logic signed [VALUE_W-1:0] cell_hval [CAPACITY];
   logic [POS_W-1:0]          slot;
   logic signed [VALUE_W-1:0] found;

   assign busy   = (state_ff != S_IDLE);
   assign accept = start && !busy;

   // Decode of the captured operation.
   always_comb begin
      is_insert = (op_ff == OP_INSERT);
      is_remove = (op_ff == OP_REMOVE);
      full      = (count_ff >= CAP_C);
      rank_ok   = CMP_W'(rank_ff) < CMP_W'(count_ff);
   end

   // Command broadcast to the cells during the execute cycle.
   always_comb begin
      cmd.active    = (state_ff == S_EXEC);
      cmd.op_insert = is_insert;
      cmd.insert_go = is_insert && !full;
      cmd.remove_go = is_remove && rank_ok;
      cmd.value     = value_ff;
      cmd.rank      = rank_ff;
   end

   // Row of cells.
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g == 0) begin : g_first
         slist_cell #(.INDEX(g), .CNT_W(CNT_W)) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .count      (count_ff),
            .le_left    (1'b1),
            .le_out     (le_chain[g]),
            .left_val   (value_ff),
            .right_val  (cell_val[(g + 1 < CAPACITY) ? g + 1 : g]),
            .stored_val (cell_val[g]),
            .hit        (cell_hit[g]),
            .hit_val    (cell_hval[g])
         );
      end else begin : g_rest
         slist_cell #(.INDEX(g), .CNT_W(CNT_W)) u_cell (
            .clock      (clock),
            .cmd        (cmd),
            .count      (count_ff),
            .le_left    (le_chain[g-1]),
            .le_out     (le_chain[g]),
            .left_val   (cell_val[g-1]),
            .right_val  (cell_val[(g + 1 < CAPACITY) ? g + 1 : g]),
            .stored_val (cell_val[g]),
            .hit        (cell_hit[g]),
            .hit_val    (cell_hval[g])
         );
      end
   end

   // Gather the single hitting cell's rank and value across the row.
   always_comb begin
      slot  = '0;
      found = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         if (cell_hit[i]) begin
            slot = slot | POS_W'(i);
         end
         found = found | cell_hval[i];
      end
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:   if (accept) state_in = S_EXEC;
         S_EXEC:   state_in = S_REDUCE;
         S_REDUCE: state_in = S_IDLE;
         default:  state_in = S_IDLE;
      endcase
   end

   // Count update and status in the execute cycle.
   always_comb begin
      count_in  = count_ff;
      status_in = status_ff;
      if (state_ff == S_EXEC) begin
         if (is_insert) begin
            status_in = full ? STAT_FULL : STAT_DONE;
            if (!full) count_in = count_ff + 1'b1;
         end else begin
            status_in = rank_ok ? STAT_DONE : STAT_NO_RANK;
            if (is_remove && rank_ok) count_in = count_ff - 1'b1;
         end
      end
   end

   // Result fields.
   always_comb begin
      count_ext = (CNT_W + OCC_W)'(count_ff);
      if (is_insert) begin
         position_in  = (status_ff == STAT_FULL) ? '0 : slot;
         value_out_in = '0;
      end else begin
         position_in  = rank_ff;
         value_out_in = (status_ff == STAT_DONE) ? found : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= (state_ff == S_REDUCE);
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff    <= req_operation;
         value_ff <= req_value;
         rank_ff  <= req_rank;
      end
      status_ff <= status_in;
      if (state_ff == S_REDUCE) begin
         rsp_status_ff    <= status_ff;
         rsp_position_ff  <= position_in;
         rsp_value_ff     <= value_out_in;
         rsp_occupancy_ff <= count_ext[OCC_W-1:0];
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_position    = rsp_position_ff;
   assign rsp_entry_value = rsp_value_ff;
   assign rsp_occupancy   = rsp_occupancy_ff;

   // The occupancy never exceeds the capacity.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CAP_C) else $error("entry count above capacity");

   // A transfer always moves the sequencer into the execute cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == S_EXEC) else $error("accepted operation not executed");

   // A result is shown only right after the gather cycle.
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(state_ff) == S_REDUCE) else $error("unexpected result strobe");

   // A dropped insert reports no rank and no value.
   a_full_resp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_status == STAT_FULL |-> rsp_position == '0 && rsp_entry_value == '0)
      else $error("full response carries data");

endmodule

### rtl/slist_cell.sv
module slist_cell #(
   parameter int INDEX = 0,
   parameter int CNT_W = 7
) (
   input  logic                               clock,
   input  slist_pkg::cell_cmd_type            cmd,
   input  logic [CNT_W-1:0]                   count,
   input  logic                               le_left,
   output logic                               le_out,
   input  logic signed [slist_pkg::VALUE_W-1:0] left_val,
   input  logic signed [slist_pkg::VALUE_W-1:0] right_val,
   output logic signed [slist_pkg::VALUE_W-1:0] stored_val,
   output logic                               hit,
   output logic signed [slist_pkg::VALUE_W-1:0] hit_val
);
   import slist_pkg::*;

   localparam logic [CNT_W-1:0] IDX_C   = CNT_W'(INDEX);
   localparam logic [31:0]      IDX_W32 = 32'(INDEX);

   logic signed [VALUE_W-1:0] stored_ff, stored_in;
   logic                      hit_ff, hit_in;
   logic signed [VALUE_W-1:0] hit_val_ff, hit_val_in;
   logic                      valid, le_own, boundary, rank_match, rank_ge;

   // Local view of the list: occupancy and ordering against the new value.
   always_comb begin
      valid      = count > IDX_C;
      le_own     = valid && (stored_ff <= cmd.value);
      boundary   = le_left && !le_own;
      rank_match = (32'(cmd.rank) == IDX_W32);
      rank_ge    = (32'(cmd.rank) <= IDX_W32);
   end

   assign le_out = le_own;

   // Insert opens a gap at the boundary and shifts right; remove shifts left.
   always_comb begin
      stored_in = stored_ff;
      if (cmd.active && cmd.insert_go && !le_own) begin
         stored_in = le_left ? cmd.value : left_val;
      end else if (cmd.active && cmd.remove_go && rank_ge) begin
         stored_in = right_val;
      end
   end

   // This cell's share of the answer, taken from the contents before the update.
   always_comb begin
      hit_in     = cmd.op_insert ? boundary : rank_match;
      hit_val_in = (!cmd.op_insert && rank_match) ? stored_ff : '0;
   end

   always_ff @(posedge clock) begin
      stored_ff <= stored_in;
      if (cmd.active) begin
         hit_ff     <= hit_in;
         hit_val_ff <= hit_val_in;
      end
   end

   assign stored_val = stored_ff;
   assign hit        = hit_ff;
   assign hit_val    = hit_val_ff;

endmodule

### bench/sorted_list_checker.sv
// Watches both channels of the sorted list, keeps its own copy of the list,
// and compares every result transfer with the oldest expected result.
module sorted_list_checker #(
   parameter int CAPACITY = slist_pkg::CAPACITY_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic                                 busy,
   input  logic [slist_pkg::OP_W-1:0]           req_operation,
   input  logic signed [slist_pkg::VALUE_W-1:0] req_value,
   input  logic [slist_pkg::RANK_W-1:0]         req_rank,
   input  logic                                 rsp_strobe,
   input  logic [slist_pkg::STAT_W-1:0]         rsp_status,
   input  logic [slist_pkg::POS_W-1:0]          rsp_position,
   input  logic signed [slist_pkg::VALUE_W-1:0] rsp_entry_value,
   input  logic [slist_pkg::OCC_W-1:0]          rsp_occupancy,
   output int                                   fail_count,
   output int                                   pending
);
   import slist_pkg::*;

   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      logic [STAT_W-1:0]         status;
      logic [POS_W-1:0]          position;
      logic signed [VALUE_W-1:0] entry_value;
      logic [OCC_W-1:0]          occupancy;
   } list_answer_type;

   // Shadow copy of the list contents and the number of stored entries.
   logic signed [VALUE_W-1:0] shadow_entries [CAPACITY];
   int                        shadow_count;

   list_answer_type answer_q [$];
   int              issued;
   int              completed;
   int              failures;

   assign pending = issued - completed;

   initial begin
      fail_count = 0;
      issued = 0;
      completed = 0;
      failures = 0;
      shadow_count = 0;
   end

   // Applies one operation to the shadow list and returns the answer it implies.
   function automatic list_answer_type apply_operation(
      input logic [OP_W-1:0]          op,
      input logic signed [VALUE_W-1:0] value,
      input logic [RANK_W-1:0]         rank
   );
      list_answer_type ans;
      int slot;
      int i;
      logic signed [VALUE_W-1:0] found;
      ans.status = STAT_DONE;
      ans.position = '0;
      ans.entry_value = '0;
      if (op == OP_INSERT) begin
         if (shadow_count >= CAPACITY) begin
            ans.status = STAT_FULL;
         end else begin
            // Equal values go behind the ones already stored.
            slot = 0;
            while (slot < shadow_count && shadow_entries[slot] <= value) slot++;
            for (i = shadow_count; i > slot; i--) shadow_entries[i] = shadow_entries[i-1];
            shadow_entries[slot] = value;
            shadow_count++;
            ans.position = slot[POS_W-1:0];
         end
      end else if (int'(rank) >= shadow_count) begin
         ans.status = STAT_NO_RANK;
         ans.position = rank;
      end else begin
         // Remove closes the gap; read and the unused code leave the list alone.
         found = shadow_entries[rank];
         if (op == OP_REMOVE) begin
            for (i = int'(rank); i + 1 < shadow_count; i++) begin
               shadow_entries[i] = shadow_entries[i+1];
            end
            shadow_count--;
         end
         ans.position = rank;
         ans.entry_value = found;
      end
      ans.occupancy = shadow_count[OCC_W-1:0];
      return ans;
   endfunction

   // Compare result transfers first, then predict the input transfer of this edge.
   always @(posedge clock) begin : watch
      list_answer_type got;
      list_answer_type want;
      if (reset) begin
         shadow_count = 0;
         answer_q.delete();
      end else begin
         if (rsp_strobe) begin
            got.status = rsp_status;
            got.position = rsp_position;
            got.entry_value = rsp_entry_value;
            got.occupancy = rsp_occupancy;
            if (answer_q.size() == 0) begin
               if (failures < REPORT_LIMIT) begin
                  $display("unexpected result: status %0d position %0d value %0d occupancy %0d",
                           got.status, got.position, got.entry_value, got.occupancy);
               end
               failures++;
            end else begin
               want = answer_q.pop_front();
               completed <= completed + 1;
               if (got.status !== want.status || got.position !== want.position ||
                   got.entry_value !== want.entry_value ||
                   got.occupancy !== want.occupancy) begin
                  if (failures < REPORT_LIMIT) begin
                     $display("mismatch: expected status %0d position %0d value %0d occupancy %0d",
                              want.status, want.position, want.entry_value, want.occupancy);
                     $display("          actual   status %0d position %0d value %0d occupancy %0d",
                              got.status, got.position, got.entry_value, got.occupancy);
                  end
                  failures++;
               end
            end
         end
         if (start && !busy) begin
            answer_q.push_back(apply_operation(req_operation, req_value, req_rank));
            issued <= issued + 1;
         end
      end
      fail_count <= failures;
   end

endmodule

### bench/sorted_list_insert_remove_tb.sv
// Drives operations into the sorted list and gives the verdict.
module sorted_list_insert_remove_tb;
   import slist_pkg::*;

   localparam int CAPACITY       = CAPACITY_DEFAULT;
   localparam int WATCHDOG_LIMIT = 500;
   localparam int SETTLE_CYCLES  = 8;
   localparam int PHASES         = 6;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
   localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      start = 1'b0;
   logic                      busy;
   logic [OP_W-1:0]           req_operation = OP_INSERT;
   logic signed [VALUE_W-1:0] req_value = '0;
   logic [RANK_W-1:0]         req_rank = '0;
   logic                      rsp_strobe;
   logic [STAT_W-1:0]         rsp_status;
   logic [POS_W-1:0]          rsp_position;
   logic signed [VALUE_W-1:0] rsp_entry_value;
   logic [OCC_W-1:0]          rsp_occupancy;
   int                        fail_count;
   int                        pending;
   int                        idle_cycles = 0;

   // Per-phase mix: length, percentage of inserts, percentage of items followed by a gap.
   int phase_len  [PHASES] = '{160, 140, 120, 140, 130, 140};
   int insert_pct [PHASES] = '{94, 50, 12, 90, 45, 60};
   int gap_pct    [PHASES] = '{25, 0, 30, 20, 35, 0};

   always #10 clock = ~clock;

   sorted_list_insert_remove #(.CAPACITY(CAPACITY)) u_dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .req_rank        (req_rank),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_entry_value (rsp_entry_value),
      .rsp_occupancy   (rsp_occupancy)
   );

   sorted_list_checker #(.CAPACITY(CAPACITY)) u_checker (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_operation   (req_operation),
      .req_value       (req_value),
      .req_rank        (req_rank),
      .rsp_strobe      (rsp_strobe),
      .rsp_status      (rsp_status),
      .rsp_position    (rsp_position),
      .rsp_entry_value (rsp_entry_value),
      .rsp_occupancy   (rsp_occupancy),
      .fail_count      (fail_count),
      .pending         (pending)
   );

   // The watchdog ends the run when no transfer happens on either channel for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("sorted_list_insert_remove_tb NOT OK");
            $finish;
         end
      end
   end

   // Presents one operation and holds it until the block takes the transfer.
   task automatic send_op(input logic [OP_W-1:0] op, input logic signed [VALUE_W-1:0] value,
                          input logic [RANK_W-1:0] rank);
      start <= 1'b1;
      req_operation <= op;
      req_value <= value;
      req_rank <= rank;
      do @(posedge clock); while (busy);
   endtask

   // Drops start for a random burst of cycles.
   task automatic idle_burst();
      start <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clock);
   endtask

   // Holds off new operations until every outstanding result has come back.
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   // Values lean toward a few small numbers so that duplicates are common.
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0: return $signed($urandom_range(0, 7)) - 4;
         1: begin
            case ($urandom_range(0, 3))
               0: return VALUE_MIN;
               1: return VALUE_MAX;
               2: return '0;
               default: return -1;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [RANK_W-1:0] pick_rank();
      if ($urandom_range(0, 1) == 1) return RANK_W'($urandom_range(0, 63));
      return RANK_W'($urandom_range(0, 15));
   endfunction

   initial begin : stimulus
      int p;
      int n;
      int sel;
      logic [OP_W-1:0] op;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // Directed part: empty list, extreme values, duplicates, ends of the list.
      send_op(OP_READ, VALUE_MAX, 6'd0);
      send_op(OP_REMOVE, VALUE_MIN, 6'd63);
      send_op(OP_UNUSED, '0, 6'd0);
      send_op(OP_INSERT, '0, 6'd63);
      send_op(OP_INSERT, VALUE_MAX, 6'd0);
      send_op(OP_INSERT, VALUE_MIN, 6'd0);
      send_op(OP_INSERT, -1, 6'd0);
      send_op(OP_INSERT, '0, 6'd0);
      send_op(OP_INSERT, 32'sd1, 6'd0);
      send_op(OP_INSERT, VALUE_MIN, 6'd0);
      send_op(OP_READ, '0, 6'd0);
      send_op(OP_READ, '0, 6'd6);
      send_op(OP_READ, '0, 6'd7);
      send_op(OP_UNUSED, -1, 6'd2);
      send_op(OP_READ, '0, 6'd63);
      send_op(OP_REMOVE, '0, 6'd6);
      send_op(OP_REMOVE, '0, 6'd0);
      send_op(OP_REMOVE, '0, 6'd2);
      send_op(OP_REMOVE, '0, 6'd63);
      send_op(OP_READ, '0, 6'd0);
      drain();

      // Random part: phases swing the list between full and nearly empty.
      for (p = 0; p < PHASES; p++) begin
         for (n = 0; n < phase_len[p]; n++) begin
            sel = $urandom_range(0, 99);
            if (sel < insert_pct[p]) begin
               op = OP_INSERT;
            end else begin
               sel = $urandom_range(0, 99);
               if (sel < 55) op = OP_REMOVE;
               else if (sel < 95) op = OP_READ;
               else op = OP_UNUSED;
            end
            send_op(op, (op == OP_INSERT) ? pick_value() : $urandom, pick_rank());
            if ($urandom_range(0, 99) < gap_pct[p]) idle_burst();
         end
         drain();
      end

      // Let the last results arrive, then let the bench settle before the verdict.
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("sorted_list_insert_remove_tb OK");
      end else begin
         $display("sorted_list_insert_remove_tb NOT OK");
      end
      $finish;
   end

endmodule
